FILE: rtl/core/cgbs_pkg.sv
// Shared constants, codes and types of the column green boundary scan.
package cgbs_pkg;

	localparam int unsigned CGBS_COLUMN_ROWS = 256;
	localparam int unsigned CGBS_MAX_COLUMNS = 256;

	// Pixel classes
	localparam logic [1:0] COL_OTHER = 2'd0;
	localparam logic [1:0] COL_GREEN = 2'd1;
	localparam logic [1:0] COL_WHITE = 2'd2;
	localparam logic [1:0] COL_BACK  = 2'd3;

	// Result status codes
	localparam logic [1:0] STAT_NONE      = 2'd0;
	localparam logic [1:0] STAT_BOUNDARY  = 2'd1;
	localparam logic [1:0] STAT_GREEN_TOP = 2'd2;
	localparam logic [1:0] STAT_FIELDLINE = 2'd3;

	localparam logic [8:0] GREEN_TOP_MAX = 9'd511;

	// One column scan request handed from the loader to the scanner
	typedef struct packed {
		logic [7:0] start_row;
		logic [8:0] end_row;
		logic       clear_frame;
	} cgbs_job_t;

endpackage

FILE: rtl/core/cgbs_store.sv
// Column pixel store: one write port, one registered read port.
module cgbs_store #(
	parameter int unsigned DEPTH = cgbs_pkg::CGBS_COLUMN_ROWS,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [1:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [1:0]    rd_data
);

	logic [1:0] mem_q [DEPTH];
	logic [1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/core/cgbs_front.sv
// Loader: accepts pixel transactions, writes the store, issues scan jobs.
module cgbs_front #(
	parameter int unsigned COLUMN_ROWS = cgbs_pkg::CGBS_COLUMN_ROWS,
	parameter int unsigned AW          = $clog2(COLUMN_ROWS),
	parameter int unsigned RW          = $clog2(COLUMN_ROWS + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [23:0]         s_tdata,
	input  logic                s_tlast,
	input  logic                s_tuser,
	input  logic                q_empty,
	input  logic                scan_free,
	output logic                job_push,
	output cgbs_pkg::cgbs_job_t job,
	output logic                st_wr_en,
	output logic [AW-1:0]       st_wr_addr,
	output logic [1:0]          st_wr_data
);

	logic          accept;
	logic          room;
	logic [RW-1:0] load_row_q;
	logic          clear_pend_q;

	// Hold pixels back while a scan is queued or reading the store
	assign s_tready = q_empty && scan_free;
	assign accept   = s_tvalid && s_tready;
	assign room     = (load_row_q < RW'(COLUMN_ROWS));

	assign st_wr_en   = accept && room;
	assign st_wr_addr = load_row_q[AW-1:0];
	assign st_wr_data = s_tdata[1:0];

	assign job_push        = accept && s_tlast;
	assign job.start_row   = s_tdata[9:2];
	assign job.end_row     = s_tdata[18:10];
	assign job.clear_frame = clear_pend_q || s_tuser;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_row_q   <= '0;
			clear_pend_q <= 1'b0;
		end else if (accept) begin
			if (s_tlast) begin
				load_row_q   <= '0;
				clear_pend_q <= 1'b0;
			end else begin
				if (room) begin
					load_row_q <= load_row_q + RW'(1);
				end
				clear_pend_q <= clear_pend_q || s_tuser;
			end
		end
	end

endmodule

FILE: rtl/core/cgbs_queue.sv
// Two-entry job queue between loader and scanner.
module cgbs_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  cgbs_pkg::cgbs_job_t push_job,
	input  logic                pop,
	output cgbs_pkg::cgbs_job_t pop_job,
	output logic                empty,
	output logic                full
);

	cgbs_pkg::cgbs_job_t ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign empty   = (count_q == 2'd0);
	assign full    = (count_q == 2'd2);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_job = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/cgbs_back.sv
// Scanner: walks the store for a green run and produces the column result.
module cgbs_back #(
	parameter int unsigned COLUMN_ROWS = cgbs_pkg::CGBS_COLUMN_ROWS,
	parameter int unsigned MAX_COLUMNS = cgbs_pkg::CGBS_MAX_COLUMNS,
	parameter int unsigned AW          = $clog2(COLUMN_ROWS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [8:0]          fieldline_rows,
	input  logic                q_empty,
	input  cgbs_pkg::cgbs_job_t q_job,
	output logic                q_pop,
	output logic                scan_free,
	output logic                st_rd_en,
	output logic [AW-1:0]       st_rd_addr,
	input  logic [1:0]          st_rd_data,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [31:0]         m_tdata,
	output logic [1:0]          m_tuser
);

	localparam int unsigned RW  = $clog2(COLUMN_ROWS + 1);
	localparam int unsigned CW  = (RW > 10) ? RW : 10;
	localparam int unsigned CCW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

	typedef enum logic [2:0] {
		BK_IDLE = 3'b001,
		BK_SCAN = 3'b010,
		BK_DONE = 3'b100
	} bk_state_t;

	bk_state_t      state_q;
	logic [CW-1:0]  start_q;
	logic [CW-1:0]  end_q;
	logic [CW-1:0]  fl_q;
	logic [CW-1:0]  lim_q;
	logic [CW-1:0]  rd_row_q;
	logic           rd_vld_s1;
	logic [CW-1:0]  rd_row_s1;
	logic           g_q, w_q, act_q, hit_q, poss_q;
	logic [CW-1:0]  run_start_q;
	logic [CCW-1:0] col_q;
	logic [8:0]     gtc_q;
	logic           out_vld_q;
	logic [1:0]     out_stat_q;
	logic [7:0]     out_brow_q;
	logic [7:0]     out_col_q;
	logic [8:0]     out_gtc_q;

	logic           g_n, w_n, act_n, hit_n, poss_n;
	logic [CW-1:0]  run_start_n;
	logic [CW-1:0]  row_nx;
	logic           stop_now;
	logic           finish;
	logic           issue;
	logic [CW-1:0]  job_start;
	logic [CW-1:0]  job_end;
	logic [CW-1:0]  job_fl;
	logic [CW:0]    fl_limit;
	logic [1:0]     stat;
	logic [8:0]     gtc_next;
	logic           out_free;
	logic [31:0]    col_ext;

	assign scan_free = (state_q != BK_SCAN);
	assign q_pop     = (state_q == BK_IDLE) && !q_empty;

	// Clamp the scan end and field-line rows to the store depth
	always_comb begin
		job_start = CW'(q_job.start_row);
		job_end   = (CW'(q_job.end_row) > CW'(COLUMN_ROWS)) ? CW'(COLUMN_ROWS)
		                                                   : CW'(q_job.end_row);
		job_fl    = (CW'(fieldline_rows) > CW'(COLUMN_ROWS)) ? CW'(COLUMN_ROWS)
		                                                    : CW'(fieldline_rows);
	end

	// Run tracker on the registered store word
	always_comb begin
		g_n         = g_q;
		w_n         = w_q;
		act_n       = act_q;
		hit_n       = hit_q;
		poss_n      = poss_q;
		run_start_n = run_start_q;
		row_nx      = rd_row_s1 + CW'(1);
		if (rd_vld_s1) begin
			if (rd_row_s1 < fl_q && st_rd_data == cgbs_pkg::COL_WHITE) begin
				poss_n = 1'b1;
			end
			if (rd_row_s1 < end_q && !hit_q) begin
				priority if (st_rd_data == cgbs_pkg::COL_GREEN) begin
					if (g_q) begin
						hit_n = 1'b1;
					end else begin
						g_n = 1'b1;
						w_n = 1'b0;
						if (!act_q) begin
							act_n       = 1'b1;
							run_start_n = rd_row_s1;
						end
					end
				end else if ((st_rd_data == cgbs_pkg::COL_WHITE ||
				              st_rd_data == cgbs_pkg::COL_BACK) && !w_q && g_q) begin
					w_n = 1'b1;
				end else if (st_rd_data == cgbs_pkg::COL_WHITE && !g_q) begin
					act_n       = 1'b1;
					run_start_n = rd_row_s1;
					w_n         = 1'b1;
				end else begin
					g_n   = 1'b0;
					w_n   = 1'b0;
					act_n = 1'b0;
				end
			end
		end
		stop_now = rd_vld_s1 && (hit_n || row_nx >= end_q) && (poss_n || row_nx >= fl_q);
	end

	assign finish     = (state_q == BK_SCAN) &&
	                    (stop_now || (!rd_vld_s1 && rd_row_q >= lim_q));
	assign issue      = (state_q == BK_SCAN) && !finish && (rd_row_q < lim_q);
	assign st_rd_en   = issue;
	assign st_rd_addr = rd_row_q[AW-1:0];

	// Classify the finished scan
	always_comb begin
		fl_limit = {1'b0, start_q} + (CW + 1)'(fieldline_rows);
		stat     = cgbs_pkg::STAT_NONE;
		if (hit_q) begin
			priority if (poss_q && {1'b0, run_start_q} < fl_limit) begin
				stat = cgbs_pkg::STAT_FIELDLINE;
			end else if (run_start_q != '0) begin
				stat = cgbs_pkg::STAT_BOUNDARY;
			end else begin
				stat = cgbs_pkg::STAT_GREEN_TOP;
			end
		end
		gtc_next = gtc_q;
		if (stat == cgbs_pkg::STAT_GREEN_TOP && gtc_q < cgbs_pkg::GREEN_TOP_MAX) begin
			gtc_next = gtc_q + 9'd1;
		end
		col_ext = 32'(col_q);
	end

	assign out_free = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			rd_vld_s1 <= 1'b0;
			col_q     <= '0;
			gtc_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (state_q == BK_DONE && out_free) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			rd_vld_s1 <= issue;
			unique case (state_q)
				BK_IDLE: begin
					if (!q_empty) begin
						if (q_job.clear_frame) begin
							col_q <= '0;
							gtc_q <= '0;
						end
						state_q <= BK_SCAN;
					end
				end
				BK_SCAN: begin
					if (finish) begin
						state_q <= BK_DONE;
					end
				end
				BK_DONE: begin
					if (out_free) begin
						gtc_q     <= gtc_next;
						col_q     <= (col_q == CCW'(MAX_COLUMNS - 1)) ? '0 : col_q + CCW'(1);
						state_q   <= BK_IDLE;
					end
				end
				default: state_q <= BK_IDLE;
			endcase
		end
	end

	// Datapath registers of the scan and the result
	always_ff @(posedge clk) begin
		rd_row_s1 <= rd_row_q;
		if (issue) begin
			rd_row_q <= rd_row_q + CW'(1);
		end
		if (state_q == BK_IDLE) begin
			start_q     <= job_start;
			end_q       <= job_end;
			fl_q        <= job_fl;
			lim_q       <= (job_end > job_fl) ? job_end : job_fl;
			rd_row_q    <= job_start;
			g_q         <= 1'b0;
			w_q         <= 1'b0;
			act_q       <= 1'b0;
			hit_q       <= 1'b0;
			poss_q      <= 1'b0;
			run_start_q <= '0;
		end else if (state_q == BK_SCAN) begin
			g_q         <= g_n;
			w_q         <= w_n;
			act_q       <= act_n;
			hit_q       <= hit_n;
			poss_q      <= poss_n;
			run_start_q <= run_start_n;
		end
		if (state_q == BK_DONE && out_free) begin
			out_stat_q <= stat;
			out_brow_q <= (stat == cgbs_pkg::STAT_BOUNDARY) ? run_start_q[7:0] : 8'd0;
			out_col_q  <= col_ext[7:0];
			out_gtc_q  <= gtc_next;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_stat_q;
	assign m_tdata  = {7'd0, out_gtc_q, out_col_q, out_brow_q};

endmodule

FILE: rtl/core/column_green_boundary_scan_top.sv
// Top level of the column green boundary scan.
//
// Pixels of one image column arrive top row first, one transaction per cycle while
// s_tready is high, and are written into a column store of COLUMN_ROWS two-bit
// entries. The transaction marked tlast closes the column and queues a scan
// job; the scanner then reads the store one row per cycle from start_row up
// to the larger of end_row and fieldline_rows (both clamped to COLUMN_ROWS),
// stopping early once the green run and the field-line test are settled, and
// writes one result transaction. The single column store, which the next
// column would overwrite, is why new pixels are held off while a scan reads
// the store. A finished result waits in an output register, so pixel loading
// of the next column goes on while the result is not yet taken. Store entries
// are never cleared: rows a column did not load read whatever an earlier
// column left there. new_frame in tuser clears the column index and the
// green-top count before the column's result is made. Write fieldline_rows
// only while the block is idle.
module column_green_boundary_scan_top #(
	parameter int unsigned COLUMN_ROWS = cgbs_pkg::CGBS_COLUMN_ROWS,
	parameter int unsigned MAX_COLUMNS = cgbs_pkg::CGBS_MAX_COLUMNS
) (
	input  logic        clk,
	input  logic        arst_n,
	// Pixel stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // colour[1:0], start_row[9:2], end_row[18:10], zero fill
	input  logic        s_tlast,   // last_in_column
	input  logic        s_tuser,   // new_frame
	// Column result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // boundary_row[7:0], column_index[15:8],
	                               // green_top_total[24:16], zero fill
	output logic [1:0]  m_tuser,   // status
	// Configuration: fieldline_rows
	input  logic        cfg_we,
	input  logic [8:0]  cfg_wdata
);

	localparam int unsigned AW = $clog2(COLUMN_ROWS);
	localparam int unsigned RW = $clog2(COLUMN_ROWS + 1);

	logic [8:0]          fieldline_rows_q;
	logic                q_empty;
	logic                q_full;
	logic                job_push;
	logic                q_pop;
	logic                scan_free;
	cgbs_pkg::cgbs_job_t push_job;
	cgbs_pkg::cgbs_job_t pop_job;
	logic                st_wr_en;
	logic [AW-1:0]       st_wr_addr;
	logic [1:0]          st_wr_data;
	logic                st_rd_en;
	logic [AW-1:0]       st_rd_addr;
	logic [1:0]          st_rd_data;

	// Field-line rows register; zero disables the field-line test
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fieldline_rows_q <= 9'd0;
		end else if (cfg_we) begin
			fieldline_rows_q <= cfg_wdata;
		end
	end

	// Loader: store pixels and close columns
	cgbs_front #(
		.COLUMN_ROWS(COLUMN_ROWS),
		.AW         (AW),
		.RW         (RW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.q_empty   (q_empty),
		.scan_free (scan_free),
		.job_push  (job_push),
		.job       (push_job),
		.st_wr_en  (st_wr_en),
		.st_wr_addr(st_wr_addr),
		.st_wr_data(st_wr_data)
	);

	// Job queue; the loader only pushes when it is empty, so full never stalls
	cgbs_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (job_push && !q_full),
		.push_job(push_job),
		.pop     (q_pop),
		.pop_job (pop_job),
		.empty   (q_empty),
		.full    (q_full)
	);

	// Column store
	cgbs_store #(
		.DEPTH(COLUMN_ROWS),
		.AW   (AW)
	) u_store (
		.clk    (clk),
		.wr_en  (st_wr_en),
		.wr_addr(st_wr_addr),
		.wr_data(st_wr_data),
		.rd_en  (st_rd_en),
		.rd_addr(st_rd_addr),
		.rd_data(st_rd_data)
	);

	// Scanner and result register
	cgbs_back #(
		.COLUMN_ROWS(COLUMN_ROWS),
		.MAX_COLUMNS(MAX_COLUMNS),
		.AW         (AW)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.fieldline_rows(fieldline_rows_q),
		.q_empty       (q_empty),
		.q_job         (pop_job),
		.q_pop         (q_pop),
		.scan_free     (scan_free),
		.st_rd_en      (st_rd_en),
		.st_rd_addr    (st_rd_addr),
		.st_rd_data    (st_rd_data),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser)
	);

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the column green boundary scan: stream driver, monitor, predictor.
`timescale 1ns / 1ps

module tb;

	localparam int ROWS         = cgbs_pkg::CGBS_COLUMN_ROWS;
	localparam int COLUMNS      = cgbs_pkg::CGBS_MAX_COLUMNS;
	localparam int SW           = $clog2(ROWS);
	localparam int RUN_LENGTH   = 2;      // greens that close a run
	localparam int PHASE_PIXELS = 160;    // minimum pixels per random phase
	localparam int LONG_STALL   = 500;    // receiver hold-off, in cycles
	localparam int DRAIN_CYCLES = 300;    // one full column scan plus margin

	localparam logic [1:0] OTH = cgbs_pkg::COL_OTHER;
	localparam logic [1:0] GRN = cgbs_pkg::COL_GREEN;
	localparam logic [1:0] WHT = cgbs_pkg::COL_WHITE;
	localparam logic [1:0] BAK = cgbs_pkg::COL_BACK;

	typedef struct packed {
		logic [1:0] colour;
		logic [7:0] start_row;
		logic [8:0] end_row;
		logic       last;
		logic       new_frame;
	} pixel_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] boundary_row;
		logic [7:0] column_index;
		logic [8:0] green_top_total;
	} column_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_we = 1'b0;
	logic [8:0]  cfg_wdata = '0;

	// Pixels waiting for the driver, and column results the block still owes.
	pixel_t         pixel_q[$];
	column_result_t pending_columns[$];

	// Predictor state: own copy of the column store, counters and the register.
	logic [1:0] store [ROWS];
	int         load_idx = 0;
	int         col_count = 0;
	int         gt_count = 0;
	logic [8:0] fl_rows = '0;

	// Idling knobs, set by the stimulus process between phases, and the receiver's stall bookkeeping.
	int tx_gap_pct = 0;
	int rx_stall_pct = 0;
	int stall_asked = 0;
	int stall_granted = 0;
	int stall_left = 0;

	logic pix_taken = 1'b0;
	int   fails = 0;
	int   pixels_taken = 0;
	int   columns_checked = 0;
	int   settings_written = 0;

	column_green_boundary_scan_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// Store one pixel; on the column's last pixel scan it and queue the result.
	function automatic void take_pixel(input pixel_t p);
		int             first;
		int             stop;
		int             fl_lim;
		int             greens;
		int             whites;
		int             over;
		int             j;
		bit             maybe_line;
		logic [1:0]     c;
		column_result_t res;
		if (p.new_frame) begin
			col_count = 0;
			gt_count = 0;
		end
		// Drop pixels beyond the store; the write row saturates.
		if (load_idx < ROWS) begin
			store[SW'(load_idx)] = p.colour;
			load_idx++;
		end
		if (!p.last)
			return;
		first = int'(p.start_row);
		stop = (int'(p.end_row) > ROWS) ? ROWS : int'(p.end_row);
		fl_lim = (int'(fl_rows) > ROWS) ? ROWS : int'(fl_rows);
		maybe_line = 1'b0;
		for (int r = first; r < fl_lim; r++) begin
			if (store[SW'(r)] == cgbs_pkg::COL_WHITE) begin
				maybe_line = 1'b1;
				break;
			end
		end
		res.status = cgbs_pkg::STAT_NONE;
		res.boundary_row = '0;
		greens = 0;
		whites = 0;
		over = -1;
		for (int r = first; r < stop; r++) begin
			c = store[SW'(r)];
			if (c == cgbs_pkg::COL_GREEN) begin
				greens++;
				over++;
				whites = 0;
				if (greens == RUN_LENGTH) begin
					j = r - over;
					if (maybe_line && j < first + int'(fl_rows)) begin
						res.status = cgbs_pkg::STAT_FIELDLINE;
					end else if (j != 0) begin
						res.status = cgbs_pkg::STAT_BOUNDARY;
						res.boundary_row = j[7:0];
					end else begin
						res.status = cgbs_pkg::STAT_GREEN_TOP;
						if (gt_count < int'(cgbs_pkg::GREEN_TOP_MAX))
							gt_count++;
					end
					break;
				end
			end else if ((c == cgbs_pkg::COL_WHITE || c == cgbs_pkg::COL_BACK) && whites < 1
					&& greens != 0) begin
				// one gap pixel inside the run
				over++;
				whites++;
			end else if (c == cgbs_pkg::COL_WHITE && greens == 0) begin
				// white may open the run
				over = 0;
				whites = 1;
			end else begin
				greens = 0;
				whites = 0;
				over = -1;
			end
		end
		res.column_index = col_count[7:0];
		res.green_top_total = gt_count[8:0];
		col_count = (col_count + 1) % COLUMNS;
		load_idx = 0;
		pending_columns.insert(pending_columns.size(), res);
	endfunction

	function automatic logic [1:0] random_colour();
		int roll = $urandom_range(99);
		if (roll < 40)
			return cgbs_pkg::COL_GREEN;
		else if (roll < 60)
			return cgbs_pkg::COL_WHITE;
		else if (roll < 75)
			return cgbs_pkg::COL_BACK;
		return cgbs_pkg::COL_OTHER;
	endfunction

	function automatic void add_pixel(input logic [1:0] colour, input int first, input int stop,
			input bit last, input bit fresh);
		pixel_t p;
		p.colour = colour;
		p.start_row = first[7:0];
		p.end_row = stop[8:0];
		p.last = last;
		p.new_frame = fresh;
		pixel_q.insert(pixel_q.size(), p);
	endfunction

	// Queue a short column; row 0 sits in the low two bits of rows.
	function automatic void queue_column(input int n, input logic [15:0] rows, input int first,
			input int stop, input bit fresh);
		for (int i = 0; i < n; i++)
			add_pixel(rows[2*i +: 2], first, stop, i == n - 1, fresh && i == 0);
	endfunction

	// Mostly short columns scanned near the top, now and then long ones or wide bounds.
	function automatic int queue_random_column();
		int len;
		int first;
		int stop;
		bit fresh;
		len = ($urandom_range(19) == 0) ? $urandom_range(13, 260) : $urandom_range(1, 12);
		first = ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(15);
		stop = ($urandom_range(7) == 0) ? $urandom_range(256) : first + $urandom_range(20);
		if (stop > ROWS)
			stop = ROWS;
		fresh = ($urandom_range(29) == 0);
		for (int i = 0; i < len; i++)
			add_pixel(random_colour(), first, stop, i == len - 1,
				(fresh && i == 0) || $urandom_range(499) == 0);
		return len;
	endfunction

	// Hold until every queued pixel is taken and every column result has come.
	task automatic wait_for_results();
		while (pixel_q.size() != 0 || s_tvalid || pending_columns.size() != 0)
			@(posedge clk);
	endtask

	task automatic settle_block();
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_fieldline(input logic [8:0] v);
		settle_block();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		fl_rows = v;
		settings_written++;
	endtask

	task automatic run_random_phase(input logic [8:0] fl, input int tx, input int rx,
			input bit squeeze);
		int queued = 0;
		write_fieldline(fl);
		tx_gap_pct = tx;
		rx_stall_pct = rx;
		while (queued < PHASE_PIXELS)
			queued += queue_random_column();
		// Hold the result side off while pixels keep coming, so the block backs up.
		if (squeeze) begin
			@(posedge clk);
			stall_asked++;
		end
		wait_for_results();
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endtask

	// Pixel driver: advance on a taken transaction, idle at random between pixels.
	always @(negedge clk) begin : pixel_driver
		pixel_t nxt;
		if (!s_tvalid || pix_taken) begin
			if (arst_n && pixel_q.size() != 0 && $urandom_range(99) >= tx_gap_pct) begin
				nxt = pixel_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {5'b0, nxt.end_row, nxt.start_row, nxt.colour};
				s_tlast <= nxt.last;
				s_tuser <= nxt.new_frame;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls plus the long hold-off on request.
	always @(negedge clk) begin
		if (stall_asked != stall_granted) begin
			stall_granted = stall_asked;
			stall_left = LONG_STALL;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Monitor: check results against the oldest expectation, then feed taken pixels on.
	always @(posedge clk) begin : result_monitor
		column_result_t want;
		pixel_t         seen;
		pix_taken <= arst_n && s_tvalid && s_tready;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_columns.size() == 0) begin
					$error("column result with no column pending: status %0d data %h",
						m_tuser, m_tdata);
					fails++;
				end else begin
					want = pending_columns.pop_front();
					check_field("status", int'(want.status), int'(m_tuser));
					check_field("boundary_row", int'(want.boundary_row), int'(m_tdata[7:0]));
					check_field("column_index", int'(want.column_index), int'(m_tdata[15:8]));
					check_field("green_top_total", int'(want.green_top_total),
						int'(m_tdata[24:16]));
					columns_checked++;
				end
			end
			if (s_tvalid && s_tready) begin
				seen.colour = s_tdata[1:0];
				seen.start_row = s_tdata[9:2];
				seen.end_row = s_tdata[18:10];
				seen.last = s_tlast;
				seen.new_frame = s_tuser;
				take_pixel(seen);
				pixels_taken++;
			end
		end
	end

	initial begin : stimulus
		for (int i = 0; i < ROWS; i++)
			store[SW'(i)] = cgbs_pkg::COL_OTHER;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed columns, field-line check off. Most read only rows loaded so far.
		queue_column(4, 16'({OTH, OTH, GRN, GRN}), 0, 4, 1'b1);   // green at top
		queue_column(4, 16'({GRN, GRN, WHT, OTH}), 0, 4, 1'b0);   // white opens run
		// one gap tolerated, two gaps break the run
		queue_column(5, 16'({GRN, GRN, BAK, BAK, GRN}), 0, 5, 1'b0);
		queue_column(1, 16'(WHT), 2, 5, 1'b1);      // new frame on the last pixel, stale rows
		queue_column(1, 16'(OTH), 3, 1, 1'b0);      // start past end
		write_fieldline(9'd4);
		queue_column(4, 16'({GRN, GRN, OTH, WHT}), 0, 4, 1'b0);   // field line
		queue_column(4, 16'({GRN, GRN, OTH, OTH}), 0, 4, 1'b0);   // no white
		queue_column(4, 16'({WHT, OTH, GRN, GRN}), 0, 4, 1'b0);   // line beats top

		// Overlong column: fills the whole store, extra pixels dropped.
		wait_for_results();
		for (int i = 0; i < ROWS + 4; i++)
			add_pixel(random_colour(), 0, ROWS, i == ROWS + 3, 1'b0);

		// Saturate the green-top count and wrap the column index; row 1 stays green.
		write_fieldline(9'd0);
		tx_gap_pct = 10;
		rx_stall_pct = 10;
		queue_column(2, 16'({GRN, GRN}), 0, 2, 1'b1);
		repeat (int'(cgbs_pkg::GREEN_TOP_MAX) + 3)
			queue_column(1, 16'(GRN), 0, 2, 1'b0);
		wait_for_results();

		run_random_phase(9'd256, 0, 0, 1'b1);
		run_random_phase(9'd1, 67, 0, 1'b0);
		run_random_phase(9'($urandom_range(2, 60)), 0, 67, 1'b0);
		run_random_phase(9'd200, 10, 10, 1'b0);
		run_random_phase(9'd0, 0, 0, 1'b0);

		settle_block();
		$display("Covered %0d pixels and %0d column results over %0d fieldline_rows settings,",
			pixels_taken, columns_checked, settings_written);
		$display("with green-top saturation, column index wrap and a long result-side hold-off.");
		if (fails == 0)
			$display("column_green_boundary_scan_top regression: pass");
		else
			$display("column_green_boundary_scan_top regression: fail");
		$finish;
	end

	// Bound the run well past the slowest legal completion.
	initial begin
		#40_000_000;
		$display("timeout with %0d column results outstanding", pending_columns.size());
		$display("column_green_boundary_scan_top regression: fail");
		$finish;
	end

endmodule
